// ----- hdl/cfr_pkg.sv -----
`timescale 1ns / 1ps

package cfr_pkg;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_DATA = 2'd1,
    PH_CRC  = 2'd2,
    PH_FOOT = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_CRC_BAD    = 2'd1,
    ST_BAD_FOOTER = 2'd2
  } status_e;

  localparam logic KIND_WORD   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [7:0] FRAME_MARK = 8'hFF;
  localparam logic [7:0] CRC_POLY   = 8'h07;
  localparam logic [7:0] CRC_INIT   = 8'hFF;

  localparam logic [4:0] WORDS_RESET = 5'd10;

  typedef struct packed {
    logic        kind;
    logic [3:0]  index;
    logic [31:0] value;
    status_e     status;
  } res_t;

  // CRC-8, MSB first, no reflection, no final xor
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hdl/cfr_deframer.sv -----
`timescale 1ns / 1ps

module cfr_deframer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  input  logic [4:0]    frame_words_i,
  output logic          res_valid_o,
  output cfr_pkg::res_t res_o
);

  cfr_pkg::phase_e phase_q, phase_d;
  logic [5:0]      count_q, count_d;
  logic [7:0]      crc_q, crc_d;
  logic [23:0]     wb_q, wb_d;
  logic            bad_q, bad_d;

  logic [6:0] last_w;
  logic [5:0] last_idx;
  logic       at_end;
  logic [1:0] lane;

  assign last_w   = {2'b00, frame_words_i} * 7'd4 - 7'd1;
  assign last_idx = last_w[5:0];
  assign at_end   = (count_q >= last_idx);
  assign lane     = count_q[1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cfr_pkg::PH_HUNT;
      count_q <= '0;
      crc_q   <= cfr_pkg::CRC_INIT;
      wb_q    <= '0;
      bad_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      crc_q   <= crc_d;
      wb_q    <= wb_d;
      bad_q   <= bad_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    crc_d       = crc_q;
    wb_d        = wb_q;
    bad_d       = bad_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: cfr_pkg::KIND_WORD, index: 4'd0, value: 32'd0,
                    status: cfr_pkg::ST_OK};
    case (phase_q)
      cfr_pkg::PH_HUNT: begin
        if (byte_i == cfr_pkg::FRAME_MARK) begin
          phase_d = cfr_pkg::PH_DATA;
          count_d = '0;
          crc_d   = cfr_pkg::CRC_INIT;
          wb_d    = '0;
          bad_d   = 1'b0;
        end
      end
      cfr_pkg::PH_DATA: begin
        crc_d = cfr_pkg::crc8_byte(crc_q, byte_i);
        if (at_end) begin
          phase_d = cfr_pkg::PH_CRC;
        end
        if (lane != 2'd3) begin
          wb_d    = wb_q | ({16'd0, byte_i} << {lane, 3'b000});
          count_d = count_q + 6'd1;
          if (at_end) begin
            count_d = '0;
            wb_d    = '0;
          end
        end else begin
          res_valid_o = 1'b1;
          res_o.index = count_q[5:2];
          res_o.value = {byte_i, wb_q};
          wb_d        = '0;
          count_d     = at_end ? 6'd0 : count_q + 6'd1;
        end
      end
      cfr_pkg::PH_CRC: begin
        bad_d   = (byte_i != crc_q);
        phase_d = cfr_pkg::PH_FOOT;
      end
      default: begin
        res_valid_o = 1'b1;
        res_o.kind  = cfr_pkg::KIND_STATUS;
        if (byte_i != cfr_pkg::FRAME_MARK) begin
          res_o.status = cfr_pkg::ST_BAD_FOOTER;
        end else if (bad_q) begin
          res_o.status = cfr_pkg::ST_CRC_BAD;
        end
        phase_d = cfr_pkg::PH_HUNT;
        count_d = '0;
        crc_d   = cfr_pkg::CRC_INIT;
        wb_d    = '0;
        bad_d   = 1'b0;
      end
    endcase
  end

endmodule

// ----- hdl/cfr_out_buf.sv -----
`timescale 1ns / 1ps

module cfr_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cfr_pkg::res_t data_i,
  output logic          room_o,
  output logic          valid_o,
  input  logic          ready_i,
  output cfr_pkg::res_t data_o
);

  cfr_pkg::res_t mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;
  logic          pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign room_o  = (cnt_q != 2'd2);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

endmodule

// ----- hdl/crc8_frame_receiver.sv -----
`timescale 1ns / 1ps
// An accepted byte is held in the input register; when it advances, its result is written
// into the result buffer, whose occupancy drives res_valid_o.
// Throughput: one byte per cycle; the byte-wise CRC-8 network and word assembly sit
// between the input register and a two-entry result buffer, which keeps intake going
// while a result waits. Bytes stall only when both buffer entries are held.
// Reset (rst_ni low, asynchronous): hunt for header, CRC at 0xFF, buffers empty,
// payload_words back to 10.

module crc8_frame_receiver #(
  parameter int MAX_PAYLOAD_WORDS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_payload_words_i,
  // received bytes
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  // results
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic        result_kind_o,
  output logic [3:0]  word_index_o,
  output logic [31:0] word_value_o,
  output logic [1:0]  frame_status_o
);

  localparam logic [4:0] MaxWords = 5'(MAX_PAYLOAD_WORDS);

  logic [4:0]    words_q;
  logic [4:0]    frame_words;
  logic          in_valid_q;
  logic [7:0]    in_byte_q;
  logic          room;
  logic          advance;
  logic          res_valid;
  cfr_pkg::res_t res, res_out;

  // Register port never stalls; a write takes effect on the next byte.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= cfr_pkg::WORDS_RESET;
    end else if (cfg_valid_i) begin
      words_q <= cfg_payload_words_i;
    end
  end

  // Clamp the word count: zero counts as one, large values saturate.
  always_comb begin
    if (words_q == 5'd0) begin
      frame_words = 5'd1;
    end else if (words_q > MaxWords) begin
      frame_words = MaxWords;
    end else begin
      frame_words = words_q;
    end
  end

  // Advance the held byte whenever the result buffer has a free entry;
  // a new byte may enter in the same cycle the held one moves on.
  assign advance    = in_valid_q && room;
  assign rx_ready_o = !in_valid_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_ready_o) begin
      in_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_ready_o && rx_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Frame tracking, CRC and word assembly; state moves only on advance.
  cfr_deframer u_deframer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .byte_i        (in_byte_q),
    .frame_words_i (frame_words),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // Hold results until the consumer takes each transaction.
  cfr_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (advance && res_valid),
    .data_i  (res),
    .room_o  (room),
    .valid_o (res_valid_o),
    .ready_i (res_ready_i),
    .data_o  (res_out)
  );

  assign result_kind_o  = res_out.kind;
  assign word_index_o   = res_out.index;
  assign word_value_o   = res_out.value;
  assign frame_status_o = res_out.status;

endmodule

// ----- tb/sv/frame_checker.sv -----
`timescale 1ns / 1ps

package frame_tb_pkg;

  import cfr_pkg::*;

  localparam int MAX_WORDS = 16;

  // one payload byte into the running CRC-8, shifting the byte in bit by bit
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  // word count as the block applies it: zero counts as one, saturate at the maximum
  function automatic int frame_len_words(input logic [4:0] w);
    if (w == 5'd0) begin
      return 1;
    end
    if (int'(w) > MAX_WORDS) begin
      return MAX_WORDS;
    end
    return int'(w);
  endfunction

endpackage

module frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [4:0]  cfg_words_i,
  input  logic        rx_valid_i,
  input  logic        rx_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic        kind_i,
  input  logic [3:0]  index_i,
  input  logic [31:0] value_i,
  input  logic [1:0]  status_i,
  output int          fail_count_o,
  output int          pending_o
);

  import cfr_pkg::*;
  import frame_tb_pkg::*;

  logic [4:0]  words_cfg;
  phase_e      rx_phase;
  logic [5:0]  byte_cnt;
  logic [7:0]  crc_run;
  logic [23:0] held_bytes;
  logic        crc_wrong;

  res_t        awaited_results[$];
  res_t        oldest;
  int          mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic clear_frame();
    byte_cnt   = 6'd0;
    crc_run    = CRC_INIT;
    held_bytes = 24'd0;
    crc_wrong  = 1'b0;
  endtask

  // advance the deframer by one accepted byte and queue what it should emit
  task automatic deframe_byte(input logic [7:0] b);
    logic [1:0] lane;
    int         last;
    res_t       r;
    case (rx_phase)
      PH_HUNT: begin
        if (b == FRAME_MARK) begin
          rx_phase = PH_DATA;
          clear_frame();
        end
      end
      PH_DATA: begin
        crc_run = crc8_next(crc_run, b);
        lane    = byte_cnt[1:0];
        last    = frame_len_words(words_cfg) * 4 - 1;
        if (int'(byte_cnt) >= last) begin
          rx_phase = PH_CRC;
        end
        if (lane != 2'd3) begin
          held_bytes = held_bytes | (24'(b) << (8 * lane));
          byte_cnt   = byte_cnt + 6'd1;
          if (rx_phase == PH_CRC) begin
            byte_cnt   = 6'd0;
            held_bytes = 24'd0;
          end
        end else begin
          r.kind   = KIND_WORD;
          r.index  = byte_cnt[5:2];
          r.value  = {b, held_bytes};
          r.status = ST_OK;
          awaited_results.push_back(r);
          held_bytes = 24'd0;
          byte_cnt   = (rx_phase == PH_CRC) ? 6'd0 : byte_cnt + 6'd1;
        end
      end
      PH_CRC: begin
        crc_wrong = (b != crc_run);
        rx_phase  = PH_FOOT;
      end
      default: begin
        r.kind  = KIND_STATUS;
        r.index = 4'd0;
        r.value = 32'd0;
        if (b != FRAME_MARK) begin
          r.status = ST_BAD_FOOTER;
        end else begin
          r.status = crc_wrong ? ST_CRC_BAD : ST_OK;
        end
        awaited_results.push_back(r);
        rx_phase = PH_HUNT;
        clear_frame();
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_cfg = WORDS_RESET;
      rx_phase  = PH_HUNT;
      clear_frame();
      awaited_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        words_cfg = cfg_words_i;
      end
      if (rx_valid_i && rx_ready_i) begin
        deframe_byte(rx_byte_i);
      end
      if (res_valid_i && res_ready_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with nothing awaited", value_i, 32'd0);
        end else begin
          oldest = awaited_results.pop_front();
          if (kind_i != oldest.kind) begin
            report_mismatch("result_kind", 32'(kind_i), 32'(oldest.kind));
          end
          if (index_i != oldest.index) begin
            report_mismatch("word_index", 32'(index_i), 32'(oldest.index));
          end
          if (value_i != oldest.value) begin
            report_mismatch("word_value", value_i, oldest.value);
          end
          if (status_i != oldest.status) begin
            report_mismatch("frame_status", 32'(status_i), 32'(oldest.status));
          end
        end
      end
      pending_o <= awaited_results.size();
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  import cfr_pkg::*;
  import frame_tb_pkg::*;

  // Drive every input to a known value from time zero.
  logic        clk_i               = 1'b0;
  logic        rst_ni              = 1'b0;
  logic        cfg_valid_i         = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_payload_words_i = 5'd0;
  logic        rx_valid_i          = 1'b0;
  logic        rx_ready_o;
  logic [7:0]  rx_byte_i           = 8'd0;
  logic        res_valid_o;
  logic        res_ready_i         = 1'b0;
  logic        result_kind_o;
  logic [3:0]  word_index_o;
  logic [31:0] word_value_o;
  logic [1:0]  frame_status_o;

  int          fail_count;
  int          pending;

  // Idling odds in percent, changed by the stimulus between phases.
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;

  // Word count currently held by the block, mirrored here to size frames.
  logic [4:0]  words_now = WORDS_RESET;
  int          phase_bytes;
  logic [7:0]  payload_q[$];

  // Word counts per random phase: out-of-range values and both extremes included.
  int          words_plan[9] = '{2, 16, 0, 31, 3, 1, 6, 4, 5};

  crc8_frame_receiver dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_payload_words_i (cfg_payload_words_i),
    .rx_valid_i          (rx_valid_i),
    .rx_ready_o          (rx_ready_o),
    .rx_byte_i           (rx_byte_i),
    .res_valid_o         (res_valid_o),
    .res_ready_i         (res_ready_i),
    .result_kind_o       (result_kind_o),
    .word_index_o        (word_index_o),
    .word_value_o        (word_value_o),
    .frame_status_o      (frame_status_o)
  );

  frame_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_words_i  (cfg_payload_words_i),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_i   (rx_ready_o),
    .rx_byte_i    (rx_byte_i),
    .res_valid_i  (res_valid_o),
    .res_ready_i  (res_ready_i),
    .kind_i       (result_kind_o),
    .index_i      (word_index_o),
    .value_i      (word_value_o),
    .status_i     (frame_status_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Result side: stall at random on every falling edge, at the odds of the phase.
  always @(negedge clk_i) begin
    res_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Offer one byte and hold it until the transaction completes. Enter and leave on a
  // falling edge; valid gets one assignment per edge, so it never dips between bytes.
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      rx_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!rx_ready_o) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
  endtask

  // Drop valid, let every awaited result drain, then allow for bytes that are still
  // in the pipeline without producing anything.
  task automatic settle();
    rx_valid_i <= 1'b0;
    while (pending != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  // Write the word count; call only once the block has settled.
  task automatic write_words(input logic [4:0] w);
    cfg_valid_i         <= 1'b1;
    cfg_payload_words_i <= w;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    words_now = w;
  endtask

  // Fill the payload with random bytes, leaning on the all-ones and all-zeros values
  // so that header bytes turn up inside the payload.
  task automatic fill_payload(input int n);
    int r;
    payload_q.delete();
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        payload_q.push_back(8'hFF);
      end else if (r < 20) begin
        payload_q.push_back(8'h00);
      end else begin
        payload_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Send header and payload; when whole, follow with the CRC byte and the footer,
  // either of which may be spoilt on request.
  task automatic send_frame(input bit crc_good, input bit footer_good, input bit whole);
    logic [7:0] crc;
    crc = CRC_INIT;
    push_byte(FRAME_MARK);
    foreach (payload_q[i]) begin
      crc = crc8_next(crc, payload_q[i]);
      push_byte(payload_q[i]);
    end
    phase_bytes += 1 + payload_q.size();
    if (whole) begin
      push_byte(crc_good ? crc : crc ^ 8'($urandom_range(1, 255)));
      push_byte(footer_good ? FRAME_MARK : 8'($urandom_range(0, 254)));
      phase_bytes += 2;
    end
  endtask

  initial begin
    int r;
    int n_bytes;

    // Hold reset, then release it on a falling edge.
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part with one-word frames, in the first idling mode.
    send_idle_pct  = 36;
    recv_stall_pct = 49;
    write_words(5'd1);
    phase_bytes = 0;
    // Non-header bytes while hunting: ignore, no result.
    push_byte(8'h00);
    push_byte(8'h7E);
    // All-ones payload: header value taken as data, good CRC and footer.
    payload_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame(1'b1, 1'b1, 1'b1);
    // All-zeros payload with a wrong CRC: crc mismatch.
    payload_q = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_frame(1'b0, 1'b1, 1'b1);
    // Wrong CRC and wrong footer together: reported as bad footer.
    payload_q = '{8'h12, 8'h34, 8'h56, 8'h78};
    send_frame(1'b0, 1'b0, 1'b1);
    settle();

    // Random part: three idling modes, three word counts each, about 130 bytes a phase.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct  = 36;
          recv_stall_pct = 49;
        end
        1: begin
          send_idle_pct  = 49;
          recv_stall_pct = 36;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int p = 0; p < 3; p++) begin
        // A truncated frame before this point leaves the block mid-frame, so the
        // write also lands mid-frame at times.
        write_words(5'(words_plan[mode * 3 + p]));
        phase_bytes = 0;
        while (phase_bytes < 130) begin
          r       = $urandom_range(0, 99);
          n_bytes = frame_len_words(words_now) * 4;
          if (r < 75) begin
            fill_payload(n_bytes);
            send_frame($urandom_range(0, 99) < 85, $urandom_range(0, 99) < 90, 1'b1);
          end else if (r < 88) begin
            // Broken frame: stop short and let the next header fall into the payload.
            fill_payload($urandom_range(0, n_bytes - 1));
            send_frame(1'b1, 1'b1, 1'b0);
          end else begin
            // Line noise; not counted towards the phase.
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
          end
        end
        settle();
      end
    end

    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: the slowest correct run needs well under a tenth of this.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
